// ===== src/gesture_vote_filter_defines.svh =====
// assertion macros used by the gesture vote filter checker
`ifndef GESTURE_VOTE_FILTER_DEFINES_SVH
`define GESTURE_VOTE_FILTER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define GVF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset masks the check
`define GVF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/gvf_pkg.sv =====
// shared constants and types of the gesture vote filter
`default_nettype none

package gvf_pkg;

   localparam int VERDICT_W  = 4;
   localparam int CFG_IDX_W  = 2;
   localparam int CFG_DATA_W = 8;
   localparam int LEAD_OUT_W = 8;

   localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL   = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT = 2'd2;

   typedef struct packed {
      logic                 upd;
      logic                 neutral;
      logic [VERDICT_W-1:0] verdict;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== src/gvf_ifs.sv =====
// channel interfaces of the gesture vote filter
`default_nettype none

interface gvf_req_if;
   logic                          valid;
   logic                          ready;
   logic [gvf_pkg::VERDICT_W-1:0] verdict_class;
   modport source (output valid, output verdict_class, input ready);
   modport sink (input valid, input verdict_class, output ready);
endinterface

interface gvf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           new_command;
   logic [gvf_pkg::VERDICT_W-1:0]  command_class;
   logic [gvf_pkg::LEAD_OUT_W-1:0] leader_count;
   modport source (output valid, output new_command, output command_class,
                   output leader_count, input ready);
   modport sink (input valid, input new_command, input command_class,
                 input leader_count, output ready);
endinterface

interface gvf_csr_if;
   logic                           valid;
   logic                           ready;
   logic [gvf_pkg::CFG_IDX_W-1:0]  index;
   logic [gvf_pkg::CFG_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/gvf_cell.sv =====
// one class cell: vote counter, seen bit and one stage of the leader chain
`default_nettype none

module gvf_cell #(
   parameter int INDEX       = 0,
   parameter int CLS_W       = 4,
   parameter int COUNT_WIDTH = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  gvf_pkg::cell_ctrl_type              ctrl,
   input  wire  [gvf_pkg::CFG_DATA_W-1:0]      max_count,
   input  wire                                 tok_in_valid,
   input  wire  [CLS_W-1:0]                    tok_in_idx,
   input  wire  [COUNT_WIDTH-1:0]              tok_in_cnt,
   output logic                                tok_out_valid,
   output logic [CLS_W-1:0]                    tok_out_idx,
   output logic [COUNT_WIDTH-1:0]              tok_out_cnt
);
   import gvf_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   seen_ff, seen_in;
   logic                   tok_valid_ff, tok_valid_in;
   logic [CLS_W-1:0]       tok_idx_ff, tok_idx_in;
   logic [COUNT_WIDTH-1:0] tok_cnt_ff, tok_cnt_in;
   logic [COUNT_WIDTH-1:0] base;
   logic                   sel;
   logic                   take;

   assign sel  = (32'(ctrl.verdict) == INDEX);
   assign base = seen_ff ? count_ff : COUNT_WIDTH'(1);

   always_comb begin
      count_in = count_ff;
      seen_in  = seen_ff;
      if (ctrl.upd) begin
         if (ctrl.neutral) begin
            if (count_ff != '0) count_in = count_ff - COUNT_WIDTH'(1);
         end else if (sel) begin
            seen_in = 1'b1;
            if ((32'(base) < 32'(max_count)) && (base != '1))
               count_in = base + COUNT_WIDTH'(1);
            else
               count_in = base;
         end else if (seen_ff && (count_ff != '0)) begin
            count_in = count_ff - COUNT_WIDTH'(1);
         end
      end
   end

   // leader so far: first seen class along the chain (lowest index), replaced only by a strictly greater count
   assign take         = seen_ff && (!tok_in_valid || (count_ff > tok_in_cnt));
   assign tok_valid_in = tok_in_valid || seen_ff;
   assign tok_idx_in   = take ? CLS_W'(INDEX) : tok_in_idx;
   assign tok_cnt_in   = take ? count_ff : tok_in_cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         tok_valid_ff <= tok_valid_in;
      end
      tok_idx_ff <= tok_idx_in;
      tok_cnt_ff <= tok_cnt_in;
   end

   assign tok_out_valid = tok_valid_ff;
   assign tok_out_idx   = tok_idx_ff;
   assign tok_out_cnt   = tok_cnt_ff;

endmodule

`default_nettype wire

// ===== src/gesture_vote_filter.sv =====
// gesture vote filter top level: control, configuration and the cell chain
`default_nettype none

// Takes one classifier verdict per beat and returns one result beat. For a voted
// verdict all counters update at once, then the leader search walks the cell
// chain one cell per cycle, then the result is registered once the result
// register is free or its beat is being taken. The input reopens as the result
// is registered. A neutral verdict updates the counters and then registers its
// result; a verdict outside the class range goes straight to registering its
// result. One verdict is in work at a time; the result register lets the next
// verdict enter while the previous result waits. Configuration writes are taken
// in every cycle.
module gesture_vote_filter #(
   parameter int NUM_CLASSES = 16,
   parameter int COUNT_WIDTH = 8
) (
   input wire        clock,
   input wire        reset,
   gvf_req_if.sink   req_chan,
   gvf_rsp_if.source rsp_chan,
   gvf_csr_if.sink   csr_chan
);
   import gvf_pkg::*;

   localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_UPD  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CLS_W-1:0]       scan_ff, scan_in;
   logic [VERDICT_W-1:0]   verdict_ff, verdict_in;
   logic                   neutral_ff, neutral_in;
   logic                   skip_ff, skip_in;

   logic [VERDICT_W-1:0]   neutral_class_ff, neutral_class_in;
   logic [CFG_DATA_W-1:0]  tolerance_ff, tolerance_in;
   logic [CFG_DATA_W-1:0]  max_count_ff, max_count_in;

   logic [CLS_W-1:0]       last_ff, last_in;
   logic                   last_valid_ff, last_valid_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   new_cmd_ff, new_cmd_in;
   logic [VERDICT_W-1:0]   cmd_class_ff, cmd_class_in;
   logic [LEAD_OUT_W-1:0]  lead_out_ff, lead_out_in;

   logic                   req_fire;
   logic                   load;
   logic                   report;
   cell_ctrl_type          ctrl;

   logic                   tok_valid [NUM_CLASSES+1];
   logic [CLS_W-1:0]       tok_idx   [NUM_CLASSES+1];
   logic [COUNT_WIDTH-1:0] tok_cnt   [NUM_CLASSES+1];

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign ctrl.upd     = (state_ff == ST_UPD);
   assign ctrl.neutral = neutral_ff;
   assign ctrl.verdict = verdict_ff;

   assign tok_valid[0] = 1'b0;
   assign tok_idx[0]   = '0;
   assign tok_cnt[0]   = '0;

   for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cell
      gvf_cell #(
         .INDEX       (g),
         .CLS_W       (CLS_W),
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .max_count     (max_count_ff),
         .tok_in_valid  (tok_valid[g]),
         .tok_in_idx    (tok_idx[g]),
         .tok_in_cnt    (tok_cnt[g]),
         .tok_out_valid (tok_valid[g+1]),
         .tok_out_idx   (tok_idx[g+1]),
         .tok_out_cnt   (tok_cnt[g+1])
      );
   end

   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      verdict_in = verdict_ff;
      neutral_in = neutral_ff;
      skip_in    = skip_ff;
      load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               verdict_in = req_chan.verdict_class;
               neutral_in = (req_chan.verdict_class == neutral_class_ff);
               if (req_chan.verdict_class == neutral_class_ff) begin
                  skip_in  = 1'b1;
                  state_in = ST_UPD;
               end else if (32'(req_chan.verdict_class) >= NUM_CLASSES) begin
                  skip_in  = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  skip_in  = 1'b0;
                  state_in = ST_UPD;
               end
            end
         end
         ST_UPD: begin
            scan_in  = '0;
            state_in = skip_ff ? ST_FIN : ST_SCAN;
         end
         ST_SCAN: begin
            scan_in = scan_ff + CLS_W'(1);
            if (scan_ff == CLS_W'(NUM_CLASSES - 1)) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign report = !skip_ff && tok_valid[NUM_CLASSES]
                   && (32'(tok_cnt[NUM_CLASSES]) > 32'(tolerance_ff))
                   && (!last_valid_ff || (tok_idx[NUM_CLASSES] != last_ff));

   always_comb begin
      last_in       = last_ff;
      last_valid_in = last_valid_ff;
      new_cmd_in    = new_cmd_ff;
      cmd_class_in  = cmd_class_ff;
      lead_out_in   = lead_out_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         new_cmd_in   = report;
         cmd_class_in = report ? VERDICT_W'(tok_idx[NUM_CLASSES]) : '0;
         lead_out_in  = skip_ff ? '0 : LEAD_OUT_W'(tok_cnt[NUM_CLASSES]);
         if (report) begin
            last_in       = tok_idx[NUM_CLASSES];
            last_valid_in = 1'b1;
         end
      end
   end

   always_comb begin
      neutral_class_in = neutral_class_ff;
      tolerance_in     = tolerance_ff;
      max_count_in     = max_count_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            REG_NEUTRAL:   neutral_class_in = VERDICT_W'(csr_chan.data);
            REG_TOLERANCE: tolerance_in     = csr_chan.data;
            REG_MAX_COUNT: max_count_in     = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         scan_ff          <= '0;
         skip_ff          <= 1'b0;
         neutral_ff       <= 1'b0;
         neutral_class_ff <= '0;
         tolerance_ff     <= CFG_DATA_W'(3);
         max_count_ff     <= CFG_DATA_W'(8);
         last_ff          <= '0;
         last_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         scan_ff          <= scan_in;
         skip_ff          <= skip_in;
         neutral_ff       <= neutral_in;
         neutral_class_ff <= neutral_class_in;
         tolerance_ff     <= tolerance_in;
         max_count_ff     <= max_count_in;
         last_ff          <= last_in;
         last_valid_ff    <= last_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      verdict_ff   <= verdict_in;
      new_cmd_ff   <= new_cmd_in;
      cmd_class_ff <= cmd_class_in;
      lead_out_ff  <= lead_out_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.new_command   = new_cmd_ff;
   assign rsp_chan.command_class = cmd_class_ff;
   assign rsp_chan.leader_count  = lead_out_ff;

endmodule

`default_nettype wire

// ===== src/gvf_checker.sv =====
// port-level checks of the gesture vote filter and their bind
`default_nettype none

`include "gesture_vote_filter_defines.svh"

module gvf_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_valid,
   input wire                             req_ready,
   input wire                             rsp_valid,
   input wire                             rsp_ready,
   input wire                             rsp_new_command,
   input wire [gvf_pkg::VERDICT_W-1:0]    rsp_command_class,
   input wire [gvf_pkg::LEAD_OUT_W-1:0]   rsp_leader_count
);
   import gvf_pkg::*;

   `GVF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped")
   `GVF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_new_command) && $stable(rsp_command_class) && $stable(rsp_leader_count), "rsp beat changed while stalled")
   `GVF_ASSERT_IMPL(a_class_zero, clock, reset, rsp_valid && !rsp_new_command, rsp_command_class == '0, "command class set without a new command")
   `GVF_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready, "second verdict taken while one is in work")

endmodule

bind gesture_vote_filter gvf_checker u_gvf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_new_command   (rsp_chan.new_command),
   .rsp_command_class (rsp_chan.command_class),
   .rsp_leader_count  (rsp_chan.leader_count)
);

`default_nettype wire

// ===== tb/gesture_vote_filter_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the gesture vote filter: directed and random verdicts against a predictor

module gesture_vote_filter_tb;
   import gvf_pkg::*;

   localparam int NUM_CLASSES = 16;
   localparam int COUNT_WIDTH = 8;
   localparam int LONG_HOLD_CYCLES = 90;
   localparam int LONG_HOLD_AT_BEAT = 200;

   typedef struct packed {
      logic                  new_command;
      logic [VERDICT_W-1:0]  command_class;
      logic [LEAD_OUT_W-1:0] leader_count;
   } vote_result_type;

   logic clock;
   logic reset;

   gvf_req_if req_bus ();
   gvf_rsp_if rsp_bus ();
   gvf_csr_if csr_bus ();

   gesture_vote_filter #(
      .NUM_CLASSES(NUM_CLASSES),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   // predictor state and configuration
   logic [COUNT_WIDTH-1:0] vote_tally [NUM_CLASSES];
   logic                   class_known [NUM_CLASSES];
   logic [VERDICT_W-1:0]   last_command;
   logic                   command_issued;
   logic [VERDICT_W-1:0]   cfg_neutral;
   logic [7:0]             cfg_tolerance;
   logic [7:0]             cfg_max_count;

   logic [VERDICT_W-1:0] pending_verdicts [$];
   vote_result_type      expected_votes [$];
   vote_result_type      exp_vote;
   vote_result_type      got_vote;

   int   verdicts_queued;
   int   verdicts_sent;
   int   result_beats;
   int   commands_seen;
   int   mismatches;
   int   reg_writes;
   int   req_gap;
   int   rsp_stall;
   int   hold_left;
   logic hold_done;
   logic quiet_tail;

   function automatic vote_result_type predict_vote(input logic [VERDICT_W-1:0] verdict);
      vote_result_type        res;
      logic [COUNT_WIDTH-1:0] best_count;
      logic [VERDICT_W-1:0]   best_class;
      logic                   found;
      res = '0;
      best_count = '0;
      best_class = '0;
      found = 1'b0;
      if (verdict == cfg_neutral) begin
         for (int c = 0; c < NUM_CLASSES; c++)
            if (vote_tally[c] != 0) vote_tally[c]--;
         return res;
      end
      if (!class_known[verdict]) begin
         class_known[verdict] = 1'b1;
         vote_tally[verdict] = COUNT_WIDTH'(1);
      end
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (!class_known[c]) continue;
         if (c == verdict) begin
            if (vote_tally[c] < cfg_max_count && vote_tally[c] != {COUNT_WIDTH{1'b1}})
               vote_tally[c]++;
         end else if (vote_tally[c] != 0) begin
            vote_tally[c]--;
         end
         if (!found || vote_tally[c] > best_count) begin
            found = 1'b1;
            best_class = VERDICT_W'(c);
            best_count = vote_tally[c];
         end
      end
      if (best_count > cfg_tolerance && (!command_issued || best_class != last_command)) begin
         last_command = best_class;
         command_issued = 1'b1;
         res.new_command = 1'b1;
         res.command_class = best_class;
      end
      res.leader_count = best_count[LEAD_OUT_W-1:0];
      return res;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.verdict_class = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
   end

   // verdict driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.verdict_class <= '0;
         req_gap <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_votes.push_back(predict_vote(req_bus.verdict_class));
            verdicts_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_verdicts.size() != 0) begin
               req_bus.valid <= 1'b1;
               req_bus.verdict_class <= pending_verdicts.pop_front();
               if (!quiet_tail && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 7);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and scoreboard
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= 0;
         result_beats <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_beats <= result_beats + 1;
            got_vote.new_command = rsp_bus.new_command;
            got_vote.command_class = rsp_bus.command_class;
            got_vote.leader_count = rsp_bus.leader_count;
            if (got_vote.new_command === 1'b1) commands_seen++;
            if (expected_votes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result beat cmd=%b class=%0d count=%0d", $realtime,
                           got_vote.new_command, got_vote.command_class, got_vote.leader_count);
            end else begin
               exp_vote = expected_votes.pop_front();
               if (got_vote.new_command !== exp_vote.new_command ||
                   got_vote.command_class !== exp_vote.command_class ||
                   got_vote.leader_count !== exp_vote.leader_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: beat %0d exp cmd/class/count %b/%0d/%0d got %b/%0d/%0d",
                              $realtime, result_beats, exp_vote.new_command,
                              exp_vote.command_class, exp_vote.leader_count,
                              got_vote.new_command, got_vote.command_class,
                              got_vote.leader_count);
               end
            end
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_stall != 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_stall <= $urandom_range(0, 6);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // one long result back-pressure window
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && result_beats >= LONG_HOLD_AT_BEAT) begin
         hold_left <= LONG_HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      csr_bus.valid <= 1'b0;
      case (idx)
         REG_NEUTRAL:   cfg_neutral = value[VERDICT_W-1:0];
         REG_TOLERANCE: cfg_tolerance = value;
         REG_MAX_COUNT: cfg_max_count = value;
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic queue_verdict(input logic [VERDICT_W-1:0] verdict);
      pending_verdicts.push_back(verdict);
      verdicts_queued++;
   endtask

   // mostly streaks of one class, with alternations, neutral runs and noise
   task automatic queue_random_verdicts(input int count, input logic [VERDICT_W-1:0] neutral);
      int                   added;
      int                   mode;
      int                   run;
      logic [VERDICT_W-1:0] cls;
      logic [VERDICT_W-1:0] alt;
      added = 0;
      while (added < count) begin
         mode = $urandom_range(0, 9);
         cls = VERDICT_W'($urandom_range(0, NUM_CLASSES - 1));
         alt = VERDICT_W'($urandom_range(0, NUM_CLASSES - 1));
         run = (mode == 8) ? $urandom_range(1, 3) : $urandom_range(1, 10);
         for (int k = 0; k < run && added < count; k++) begin
            if (mode <= 5) queue_verdict(cls);
            else if (mode <= 7) queue_verdict(VERDICT_W'($urandom_range(0, NUM_CLASSES - 1)));
            else if (mode == 8) queue_verdict(neutral);
            else queue_verdict((k % 2) ? alt : cls);
            added++;
         end
      end
   endtask

   task automatic wait_for_drain();
      do @(posedge clock);
      while (verdicts_sent != verdicts_queued || expected_votes.size() != 0);
      repeat (NUM_CLASSES + 6) @(posedge clock);
   endtask

   task automatic run_setting(input logic [VERDICT_W-1:0] neutral, input logic [7:0] tol,
                              input logic [7:0] max_cnt, input int streak, input int count);
      write_reg(REG_NEUTRAL, {4'h0, neutral});
      write_reg(REG_TOLERANCE, tol);
      write_reg(REG_MAX_COUNT, max_cnt);
      for (int k = 0; k < streak; k++) queue_verdict(4'd6);
      queue_random_verdicts(count, neutral);
      wait_for_drain();
   endtask

   initial begin
      reset = 1'b1;
      quiet_tail = 1'b0;
      verdicts_queued = 0;
      verdicts_sent = 0;
      commands_seen = 0;
      mismatches = 0;
      reg_writes = 0;
      cfg_neutral = 4'd0;
      cfg_tolerance = 8'd3;
      cfg_max_count = 8'd8;
      last_command = '0;
      command_issued = 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         vote_tally[c] = '0;
         class_known[c] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: report, saturation, neutral decay, ties, takeover
      for (int k = 0; k < 9; k++) queue_verdict(4'd15);
      queue_verdict(4'd0);
      queue_verdict(4'd0);
      queue_verdict(4'd2);
      queue_verdict(4'd7);
      queue_verdict(4'd2);
      queue_verdict(4'd7);
      queue_verdict(4'd0);
      for (int k = 0; k < 5; k++) queue_verdict(4'd1);
      queue_verdict(4'd8);
      queue_verdict(4'd4);
      queue_verdict(4'd0);
      queue_verdict(4'd12);
      wait_for_drain();

      run_setting(4'd5, 8'd0, 8'd255, 0, 120);
      run_setting(4'd15, 8'd255, 8'd255, 260, 40);
      run_setting(4'd9, 8'd2, 8'd1, 0, 120);
      run_setting(4'd0, 8'd3, 8'd0, 0, 80);
      run_setting(4'd3, 8'd6, 8'd12, 0, 230);
      quiet_tail <= 1'b1;
      run_setting(4'd0, 8'd3, 8'd8, 0, 100);

      mismatches += expected_votes.size();
      $display("run covered %0d verdict beats over 7 settings (%0d register writes)",
               verdicts_sent, reg_writes);
      $display("%0d result beats checked, %0d of them new commands", result_beats,
               commands_seen);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout");
      $display("Verification failed");
      $finish;
   end

endmodule
